/* hdl/csc_pkg.sv */
package csc_pkg;

    localparam int NUM_KINDS       = 8;
    localparam int KIND_IDX_W      = 3;
    localparam int SEL_W           = 4;
    localparam int COUNT_WIDTH_DEF = 16;
    localparam int CFG_W           = 16;
    localparam int DISP_W          = 25;
    localparam int INTERVAL_W      = 16;
    localparam int SENSOR_W        = 7;
    localparam int WEIGHT_W        = 8;
    localparam int PADDR_W         = 4;
    localparam int PDATA_W         = 32;
    localparam int S_TDATA_W       = 32;
    localparam int M_TDATA_W       = 40;

    localparam logic [SEL_W-1:0] TOTAL_SEL = 4'd8;

    localparam logic KIND_PULSE  = 1'b0;
    localparam logic KIND_BUTTON = 1'b1;

    localparam logic [CFG_W-1:0] WINDOW_LOW_RST  = 16'd2040;
    localparam logic [CFG_W-1:0] WINDOW_HIGH_RST = 16'd2101;
    localparam logic [CFG_W-1:0] GAP_MIN_RST     = 16'd2112;
    localparam logic [CFG_W-1:0] STOP_LIMIT_RST  = 16'd32;

    localparam logic [WEIGHT_W-1:0] COIN_WEIGHT [NUM_KINDS] =
        '{8'd200, 8'd100, 8'd50, 8'd20, 8'd10, 8'd5, 8'd2, 8'd1};

    typedef enum logic [1:0] {
        REG_WINDOW_LOW,
        REG_WINDOW_HIGH,
        REG_GAP_MIN,
        REG_STOP_LIMIT
    } reg_idx_t;

    typedef struct packed {
        logic [CFG_W-1:0] window_low;
        logic [CFG_W-1:0] window_high;
        logic [CFG_W-1:0] gap_min;
        logic [CFG_W-1:0] stop_limit;
    } cfg_t;

    // classified item as it travels from front to back
    typedef struct packed {
        logic                is_button;
        logic                accum_hit;
        logic                gap_hit;
        logic [SENSOR_W-1:0] sensor;
        logic                on;
        logic                both;
        logic                euro;
        logic                clear;
    } cmd_t;

    typedef struct packed {
        logic [SEL_W-1:0] sel;
        logic [SEL_W-1:0] counted;
        logic             motor;
        logic             autostop;
        logic             latched;
    } stat_t;

    function automatic logic [SEL_W-1:0] mask_to_kind(input logic [SENSOR_W-1:0] m);
        logic [SEL_W-1:0] k;
        unique case (m)
            7'h00:   k = 4'd7;
            7'h01:   k = 4'd6;
            7'h03:   k = 4'd4;
            7'h07:   k = 4'd5;
            7'h0f:   k = 4'd3;
            7'h1f:   k = 4'd1;
            7'h3f:   k = 4'd2;
            7'h7f:   k = 4'd0;
            default: k = TOTAL_SEL;
        endcase
        return k;
    endfunction

endpackage

/* hdl/coin_sort_counter_controller.sv */
// Coin counting controller. Each transfer on the s_ side is a sensor pulse or a
// button sample; each one gives exactly one result transfer on the m_ side with the
// display value and status. One item is taken per clock cycle while the queue has
// room. The front classifies the item against the window and gap registers and
// writes it into a two-entry queue; the back applies it to the counters and forms
// the display through a four-stage product and adder pipeline. The queue takes up
// to two input transfers while a result waits on m_tready, then holds s_tready low.
module coin_sort_counter_controller #(
    parameter int COUNT_WIDTH = csc_pkg::COUNT_WIDTH_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // pulse_interval[15:0], sensor_bits[22:16], press_on[23], press_clear[24],
    // press_euro[25], zeros above
    input  logic [csc_pkg::S_TDATA_W-1:0]    s_tdata,
    // kind[0]
    input  logic                             s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // display_value[24:0], display_select[28:25], counted_kind[32:29],
    // motor_running[33], autostop_on[34], stop_latched[35], zeros above
    output logic [csc_pkg::M_TDATA_W-1:0]    m_tdata,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [csc_pkg::PADDR_W-1:0]      paddr,
    input  logic [csc_pkg::PDATA_W-1:0]      pwdata,
    output logic [csc_pkg::PDATA_W-1:0]      prdata,
    output logic                             pready
);
    import csc_pkg::*;

    cfg_t              cfg;
    cmd_t              cmd_in;
    cmd_t              cmd_q;
    logic              q_valid;
    logic              q_ready;
    logic [DISP_W-1:0] disp;
    stat_t             stat;

    csc_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    csc_front u_front (
        .s_tuser (s_tuser),
        .s_tdata (s_tdata),
        .cfg     (cfg),
        .cmd     (cmd_in)
    );

    csc_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_data   (cmd_in),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_data  (cmd_q)
    );

    csc_back #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .stop_limit (cfg.stop_limit),
        .cmd_valid  (q_valid),
        .cmd_ready  (q_ready),
        .cmd        (cmd_q),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_disp   (disp),
        .out_stat   (stat)
    );

    assign m_tdata = {4'd0, stat.latched, stat.autostop, stat.motor,
                      stat.counted, stat.sel, disp};

endmodule

/* hdl/csc_regs.sv */
module csc_regs (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [csc_pkg::PADDR_W-1:0]     paddr,
    input  logic [csc_pkg::PDATA_W-1:0]     pwdata,
    output logic [csc_pkg::PDATA_W-1:0]     prdata,
    output logic                            pready,
    output csc_pkg::cfg_t                   cfg
);
    import csc_pkg::*;

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    reg_idx_t idx;
    logic     wr_en;

    assign idx    = reg_idx_t'(paddr[PADDR_W-1:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (idx)
                REG_WINDOW_LOW:  cfg_next.window_low  = pwdata[CFG_W-1:0];
                REG_WINDOW_HIGH: cfg_next.window_high = pwdata[CFG_W-1:0];
                REG_GAP_MIN:     cfg_next.gap_min     = pwdata[CFG_W-1:0];
                REG_STOP_LIMIT:  cfg_next.stop_limit  = pwdata[CFG_W-1:0];
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_WINDOW_LOW:  prdata = PDATA_W'(cfg_reg.window_low);
            REG_WINDOW_HIGH: prdata = PDATA_W'(cfg_reg.window_high);
            REG_GAP_MIN:     prdata = PDATA_W'(cfg_reg.gap_min);
            REG_STOP_LIMIT:  prdata = PDATA_W'(cfg_reg.stop_limit);
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.window_low  <= WINDOW_LOW_RST;
            cfg_reg.window_high <= WINDOW_HIGH_RST;
            cfg_reg.gap_min     <= GAP_MIN_RST;
            cfg_reg.stop_limit  <= STOP_LIMIT_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

/* hdl/csc_front.sv */
module csc_front (
    input  logic                             s_tuser,
    input  logic [csc_pkg::S_TDATA_W-1:0]    s_tdata,
    input  csc_pkg::cfg_t                    cfg,
    output csc_pkg::cmd_t                    cmd
);
    import csc_pkg::*;

    logic [INTERVAL_W-1:0] iv;
    logic                  clr;
    logic                  eur;

    assign iv  = s_tdata[INTERVAL_W-1:0];
    assign clr = s_tdata[24];
    assign eur = s_tdata[25];

    // window and gap tests are settled here so the back only applies them
    always_comb begin
        cmd.is_button = (s_tuser == KIND_BUTTON);
        cmd.accum_hit = (iv < cfg.window_high) && (iv > cfg.window_low);
        cmd.gap_hit   = (iv > cfg.gap_min);
        cmd.sensor    = s_tdata[22:16];
        cmd.on        = s_tdata[23];
        cmd.both      = clr && eur;
        cmd.euro      = eur && !clr;
        cmd.clear     = clr && !eur;
    end

endmodule

/* hdl/csc_queue.sv */
module csc_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_valid,
    output logic           in_ready,
    input  csc_pkg::cmd_t  in_data,
    output logic           out_valid,
    input  logic           out_ready,
    output csc_pkg::cmd_t  out_data
);
    import csc_pkg::*;

    cmd_t       mem_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       push;
    logic       pop;

    assign in_ready  = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_data  = mem_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= in_data;
        end
    end

endmodule

/* hdl/csc_back.sv */
module csc_back #(
    parameter int COUNT_WIDTH = csc_pkg::COUNT_WIDTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [csc_pkg::CFG_W-1:0]     stop_limit,
    input  logic                          cmd_valid,
    output logic                          cmd_ready,
    input  csc_pkg::cmd_t                 cmd,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [csc_pkg::DISP_W-1:0]    out_disp,
    output csc_pkg::stat_t                out_stat
);
    import csc_pkg::*;

    localparam int PROD_W = COUNT_WIDTH + WEIGHT_W;
    localparam int CMP_W  = (COUNT_WIDTH > CFG_W) ? COUNT_WIDTH : CFG_W;

    // machine state
    logic [COUNT_WIDTH-1:0] cnt_reg   [NUM_KINDS];
    logic [COUNT_WIDTH-1:0] cnt_next  [NUM_KINDS];
    logic [COUNT_WIDTH-1:0] snap_reg  [NUM_KINDS];
    logic [COUNT_WIDTH-1:0] snap_next [NUM_KINDS];
    logic [COUNT_WIDTH-1:0] gain      [NUM_KINDS];
    logic [SENSOR_W-1:0]    accum_reg;
    logic [SENSOR_W-1:0]    accum_next;
    logic                   armed_reg;
    logic                   armed_next;
    logic                   motor_reg;
    logic                   motor_next;
    logic                   auto_reg;
    logic                   auto_next;
    logic                   latch_reg;
    logic                   latch_next;
    logic [SEL_W-1:0]       shown_reg;
    logic [SEL_W-1:0]       shown_next;
    logic [SEL_W-1:0]       counted;

    // display pipeline
    logic               adv;
    logic               fire;
    logic               v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    stat_t              st1_reg, st2_reg, st3_reg, st4_reg, st5_reg;
    logic [PROD_W-1:0]  prod_full [NUM_KINDS];
    logic [DISP_W-1:0]  prod_reg  [NUM_KINDS];
    logic [DISP_W-1:0]  pair_reg  [4];
    logic [DISP_W-1:0]  quad_reg  [2];
    logic [DISP_W-1:0]  sel3_reg;
    logic [DISP_W-1:0]  sel4_reg;
    logic [DISP_W-1:0]  disp_reg;

    // whole back advances together; state only moves when an item fires
    assign adv       = !v5_reg || out_ready;
    assign fire      = adv && cmd_valid;
    assign cmd_ready = adv;
    assign out_valid = v5_reg;
    assign out_disp  = disp_reg;
    assign out_stat  = st5_reg;

    always_comb begin
        cnt_next   = cnt_reg;
        snap_next  = snap_reg;
        accum_next = accum_reg;
        armed_next = armed_reg;
        motor_next = motor_reg;
        auto_next  = auto_reg;
        latch_next = latch_reg;
        shown_next = shown_reg;
        counted    = TOTAL_SEL;

        if (!cmd.is_button) begin
            if (cmd.accum_hit) begin
                accum_next = accum_reg | cmd.sensor;
                armed_next = 1'b1;
            end
            if (cmd.gap_hit && armed_next) begin
                counted = mask_to_kind(accum_next);
                if (counted != TOTAL_SEL) begin
                    cnt_next[counted[KIND_IDX_W-1:0]] =
                        cnt_reg[counted[KIND_IDX_W-1:0]] + COUNT_WIDTH'(1);
                end
                accum_next = '0;
                armed_next = 1'b0;
            end
        end else begin
            if (cmd.both) begin
                if (latch_reg) begin
                    latch_next = 1'b0;
                    motor_next = 1'b1;
                end else begin
                    auto_next = !auto_reg;
                end
            end
            if (cmd.on && !latch_next) begin
                motor_next = !motor_next;
            end
            if (cmd.euro) begin
                shown_next = (shown_reg == TOTAL_SEL) ? '0 : shown_reg + SEL_W'(1);
            end
            if (cmd.clear) begin
                for (int i = 0; i < NUM_KINDS; i++) begin
                    cnt_next[i]  = '0;
                    snap_next[i] = '0;
                end
            end
        end

        // auto-stop: the tripping kind with the highest index ends up shown
        for (int i = 0; i < NUM_KINDS; i++) begin
            gain[i] = cnt_next[i] - snap_next[i];
        end
        if (auto_next) begin
            for (int i = 0; i < NUM_KINDS; i++) begin
                if (CMP_W'(gain[i]) > CMP_W'(stop_limit)) begin
                    motor_next   = 1'b0;
                    latch_next   = 1'b1;
                    snap_next[i] = cnt_next[i];
                    shown_next   = SEL_W'(i);
                end
            end
        end
    end

    always_comb begin
        for (int i = 0; i < NUM_KINDS; i++) begin
            prod_full[i] = PROD_W'(cnt_reg[i]) * PROD_W'(COIN_WEIGHT[i]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_KINDS; i++) begin
                cnt_reg[i]  <= '0;
                snap_reg[i] <= '0;
            end
            accum_reg <= '0;
            armed_reg <= 1'b0;
            motor_reg <= 1'b0;
            auto_reg  <= 1'b0;
            latch_reg <= 1'b0;
            shown_reg <= TOTAL_SEL;
        end else if (fire) begin
            cnt_reg   <= cnt_next;
            snap_reg  <= snap_next;
            accum_reg <= accum_next;
            armed_reg <= armed_next;
            motor_reg <= motor_next;
            auto_reg  <= auto_next;
            latch_reg <= latch_next;
            shown_reg <= shown_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= cmd_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    // products are taken from the state right after the item in stage one updated it
    always_ff @(posedge aclk) begin
        if (adv) begin
            st1_reg.sel      <= shown_next;
            st1_reg.counted  <= counted;
            st1_reg.motor    <= motor_next;
            st1_reg.autostop <= auto_next;
            st1_reg.latched  <= latch_next;

            for (int i = 0; i < NUM_KINDS; i++) begin
                prod_reg[i] <= DISP_W'(prod_full[i]);
            end
            st2_reg <= st1_reg;

            for (int j = 0; j < 4; j++) begin
                pair_reg[j] <= prod_reg[2*j] + prod_reg[2*j+1];
            end
            sel3_reg <= prod_reg[st2_reg.sel[KIND_IDX_W-1:0]];
            st3_reg  <= st2_reg;

            quad_reg[0] <= pair_reg[0] + pair_reg[1];
            quad_reg[1] <= pair_reg[2] + pair_reg[3];
            sel4_reg    <= sel3_reg;
            st4_reg     <= st3_reg;

            disp_reg <= (st4_reg.sel == TOTAL_SEL) ? quad_reg[0] + quad_reg[1] : sel4_reg;
            st5_reg  <= st4_reg;
        end
    end

endmodule
